FILE: src/gtf_pkg.sv
// ----------------------------------------------------------------------------
// gtf_pkg
// Shared types, constants and helpers of the trilinear grid force block.
// ----------------------------------------------------------------------------
package gtf_pkg;

  localparam int GRID_X_DEF = 16;
  localparam int GRID_Y_DEF = 16;
  localparam int GRID_Z_DEF = 16;

  // 0.05 in Q16.16, the finite-difference step.
  localparam logic signed [32:0] STEP_Q16 = 33'sd3277;
  localparam logic signed [55:0] FORCE_SCALE = 56'sd20;
  localparam int QDEPTH = 2;

  localparam logic [1:0] STAT_OK = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_NEG = 2'd2;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_CPU_X    = 3'd3,
    CFG_CPU_Y    = 3'd4,
    CFG_CPU_Z    = 3'd5,
    CFG_GAIN     = 3'd6,
    CFG_SHIFT    = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COORD,
    ST_CHECK,
    ST_NEAR,
    ST_LOOK,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] atom_x;
    logic signed [31:0] atom_y;
    logic signed [31:0] atom_z;
    logic [3:0]         cell_ix;
    logic [3:0]         cell_iy;
    logic [3:0]         cell_iz;
    logic signed [31:0] cell_value;
  } gtf_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] energy;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } gtf_out_t;

  typedef struct packed {
    logic signed [31:0] box_origin_x;
    logic signed [31:0] box_origin_y;
    logic signed [31:0] box_origin_z;
    logic [30:0]        cells_per_unit_x;
    logic [30:0]        cells_per_unit_y;
    logic [30:0]        cells_per_unit_z;
    logic signed [31:0] energy_gain;
    logic [15:0]        grid_shift;
  } gtf_cfg_t;

  typedef struct packed {
    logic    wr_ok;
    gtf_in_t item;
  } gtf_entry_t;

  function automatic logic [31:0] sat32(input logic signed [55:0] v);
    logic [31:0] r;
    if (v > 56'sd2147483647) begin
      r = 32'h7fffffff;
    end else if (v < -56'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Corner weight: the fraction for the upper corner, one minus it for the lower.
  function automatic logic [16:0] wsel(input logic [15:0] f, input logic hi);
    logic [16:0] r;
    if (hi) begin
      r = {1'b0, f};
    end else begin
      r = 17'h10000 - {1'b0, f};
    end
    return r;
  endfunction

endpackage

FILE: src/grid_trilinear_force.sv
// ----------------------------------------------------------------------------
// grid_trilinear_force
// Energy grid with trilinear lookup and finite-difference force evaluation.
//
//   channel   signals                           direction  flow control
//   command   start, item, busy                 in         taken when start & !busy
//   result    done, result                      out        one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_data       in         taken when cfg_we
//
// A grid write gets its result beat through the queue and the result register. An
// evaluate beat goes out of the queue, through the six coordinate products, a range
// check, the nearest-cell read, 32 corner reads at one per cycle, the pipeline drain
// and the output state. A range fault ends it at the range check, a negative nearest
// value at the nearest-cell read. After reset every grid cell is cleared to zero with
// busy held high.
// ----------------------------------------------------------------------------
module grid_trilinear_force #(
  parameter int GRID_X = gtf_pkg::GRID_X_DEF,
  parameter int GRID_Y = gtf_pkg::GRID_Y_DEF,
  parameter int GRID_Z = gtf_pkg::GRID_Z_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  gtf_pkg::gtf_in_t  item,
  output logic              done,
  output gtf_pkg::gtf_out_t result,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import gtf_pkg::*;

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW = $clog2(DEPTH);

  gtf_cfg_t   cfg;
  gtf_entry_t f_entry, q_head;
  logic       push, q_valid, q_full, q_pop, clearing;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.box_origin_x <= '0;
      cfg.box_origin_y <= '0;
      cfg.box_origin_z <= '0;
      cfg.cells_per_unit_x <= 31'd65536;
      cfg.cells_per_unit_y <= 31'd65536;
      cfg.cells_per_unit_z <= 31'd65536;
      cfg.energy_gain <= 32'sd65536;
      cfg.grid_shift <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ORIGIN_X: cfg.box_origin_x <= cfg_data;
        CFG_ORIGIN_Y: cfg.box_origin_y <= cfg_data;
        CFG_ORIGIN_Z: cfg.box_origin_z <= cfg_data;
        CFG_CPU_X: cfg.cells_per_unit_x <= cfg_data[30:0];
        CFG_CPU_Y: cfg.cells_per_unit_y <= cfg_data[30:0];
        CFG_CPU_Z: cfg.cells_per_unit_z <= cfg_data[30:0];
        CFG_GAIN: cfg.energy_gain <= cfg_data;
        CFG_SHIFT: cfg.grid_shift <= cfg_data[15:0];
        default: cfg.grid_shift <= cfg.grid_shift;
      endcase
    end
  end

  gtf_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_front (
    .start(start), .item(item), .clearing(clearing), .q_full(q_full),
    .busy(busy), .push(push), .entry(f_entry)
  );

  gtf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .entry_in(f_entry), .pop(q_pop),
    .valid(q_valid), .full(q_full), .head(q_head)
  );

  gtf_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y), .GRID_Z(GRID_Z)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_entry(q_head), .q_pop(q_pop),
    .cfg(cfg), .clearing(clearing), .ram_we(ram_we), .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata), .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
    .done(done), .result(result)
  );

  gtf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

endmodule

FILE: src/gtf_ram.sv
// ----------------------------------------------------------------------------
// gtf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gtf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/gtf_front.sv
// ----------------------------------------------------------------------------
// gtf_front
// Command intake: accepts beats, range-checks write indexes, feeds the queue.
// ----------------------------------------------------------------------------
module gtf_front #(
  parameter int GRID_X = gtf_pkg::GRID_X_DEF,
  parameter int GRID_Y = gtf_pkg::GRID_Y_DEF,
  parameter int GRID_Z = gtf_pkg::GRID_Z_DEF
) (
  input  logic                start,
  input  gtf_pkg::gtf_in_t    item,
  input  logic                clearing,
  input  logic                q_full,
  output logic                busy,
  output logic                push,
  output gtf_pkg::gtf_entry_t entry
);
  import gtf_pkg::*;

  always_comb begin
    busy = q_full | clearing;
    push = start & ~busy;
    entry.item = item;
    entry.wr_ok = (32'(item.cell_ix) < 32'(GRID_X)) && (32'(item.cell_iy) < 32'(GRID_Y)) &&
                  (32'(item.cell_iz) < 32'(GRID_Z));
  end

endmodule

FILE: src/gtf_queue.sv
// ----------------------------------------------------------------------------
// gtf_queue
// Short FIFO of classified commands between intake and the evaluation engine.
// ----------------------------------------------------------------------------
module gtf_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  gtf_pkg::gtf_entry_t entry_in,
  input  logic                pop,
  output logic                valid,
  output logic                full,
  output gtf_pkg::gtf_entry_t head
);
  import gtf_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  gtf_entry_t     mem [QDEPTH];
  logic [PW-1:0]  wp;
  logic [PW-1:0]  rp;
  logic [PW:0]    count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        mem[wp] <= entry_in;
        wp <= wp + PW'(1);
      end
      if (pop) begin
        rp <= rp + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_comb begin
    valid = (count != '0);
    full = (count == (PW+1)'(QDEPTH));
    head = mem[rp];
  end

endmodule

FILE: src/gtf_back.sv
// ----------------------------------------------------------------------------
// gtf_back
// Evaluation engine: grid clearing, grid writes, coordinate mapping, and the
// pipelined trilinear accumulation over four positions with force output.
// ----------------------------------------------------------------------------
module gtf_back #(
  parameter int GRID_X = gtf_pkg::GRID_X_DEF,
  parameter int GRID_Y = gtf_pkg::GRID_Y_DEF,
  parameter int GRID_Z = gtf_pkg::GRID_Z_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_valid,
  input  gtf_pkg::gtf_entry_t                         q_entry,
  output logic                                        q_pop,
  input  gtf_pkg::gtf_cfg_t                           cfg,
  output logic                                        clearing,
  output logic                                        ram_we,
  output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0]     ram_waddr,
  output logic [31:0]                                 ram_wdata,
  output logic [$clog2(GRID_X*GRID_Y*GRID_Z)-1:0]     ram_raddr,
  input  logic [31:0]                                 ram_rdata,
  output logic                                        done,
  output gtf_pkg::gtf_out_t                           result
);
  import gtf_pkg::*;

  localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
  localparam int AW = $clog2(DEPTH);
  localparam int GMAX = (GRID_X > GRID_Y) ? ((GRID_X > GRID_Z) ? GRID_X : GRID_Z) :
                        ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
  localparam int IW = $clog2(GMAX);

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] x, input logic [AW-1:0] y,
                                            input logic [AW-1:0] z);
    return (z * AW'(GRID_Y) + y) * AW'(GRID_X) + x;
  endfunction

  function automatic logic [32:0] glim(input logic [1:0] a);
    logic [32:0] r;
    case (a)
      2'd0: r = 33'(GRID_X - 1);
      2'd1: r = 33'(GRID_Y - 1);
      default: r = 33'(GRID_Z - 1);
    endcase
    return r;
  endfunction

  back_state_t state, state_next;
  logic [5:0]    cnt, cnt_next;
  logic [AW-1:0] clr, clr_next;
  logic          done_next;
  gtf_out_t      result_next;
  gtf_entry_t    cur;

  // Coordinate stage.
  logic [1:0]          ax;
  logic                stp;
  logic signed [31:0]  psel, osel;
  logic [30:0]         cpsel;
  logic signed [32:0]  sp, ssel;
  logic signed [33:0]  dif;
  logic signed [67:0]  mul;
  logic                pv;
  logic [2:0]          ptag;
  logic signed [65:0]  prod;
  logic signed [65:0]  gsh;
  logic signed [33:0]  fi, fn;
  logic                okr, okn;

  logic [IW-1:0] idx0 [3];
  logic [IW-1:0] idx1 [3];
  logic [IW-1:0] nidx [3];
  logic [15:0]   fr0 [3];
  logic [15:0]   fr1 [3];
  logic [2:0]    ok0, ok1, nok;

  // Corner pipeline.
  logic [1:0]    q;
  logic [2:0]    k;
  logic          iv;
  logic [IW-1:0] cx, cy, cz;
  logic [16:0]   wx, wy, wz;
  logic [AW-1:0] corner_addr, near_addr, wr_addr;

  logic          v1, l1, v2, l2, v3, l3, v4;
  logic [1:0]    q1, q2, q3, q4;
  logic [33:0]   wxy;
  logic [16:0]   wz1;
  logic [50:0]   wprod;
  logic [32:0]   wt;
  logic signed [31:0] gval;
  logic signed [65:0] tprod;
  logic [63:0]   t;
  logic [63:0]   acc, sum;
  logic signed [31:0] vq;
  logic signed [63:0] gprod;
  logic signed [47:0] e [4];

  logic signed [48:0] dx, dy, dz;
  logic fault;

  // ---------------- coordinate mapping ----------------
  always_comb begin
    ax = cnt[2:1];
    stp = cnt[0];
    case (ax)
      2'd0: begin
        psel = cur.item.atom_x;
        osel = cfg.box_origin_x;
        cpsel = cfg.cells_per_unit_x;
      end
      2'd1: begin
        psel = cur.item.atom_y;
        osel = cfg.box_origin_y;
        cpsel = cfg.cells_per_unit_y;
      end
      default: begin
        psel = cur.item.atom_z;
        osel = cfg.box_origin_z;
        cpsel = cfg.cells_per_unit_z;
      end
    endcase
    sp = 33'(psel) + STEP_Q16;
    if (!sp[32] && sp[31]) begin
      sp = 33'sd2147483647;
    end
    ssel = stp ? sp : 33'(psel);
    dif = 34'(ssel) - 34'(osel);
    mul = 68'(dif) * $signed({37'b0, cpsel});

    gsh = prod + $signed({34'b0, cfg.grid_shift, 16'b0});
    fi = gsh[65:32];
    fn = prod[65:32];
    okr = !fi[33] && (fi[32:0] < glim(ptag[2:1]));
    okn = !fn[33] && (fn[32:0] <= glim(ptag[2:1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else begin
      pv <= (state == ST_COORD) && (cnt < 6'd6);
    end
    prod <= mul[65:0];
    ptag <= {ax, stp};
    if (pv) begin
      if (ptag[0]) begin
        idx1[ptag[2:1]] <= IW'(fi);
        fr1[ptag[2:1]] <= gsh[31:16];
        ok1[ptag[2:1]] <= okr;
      end else begin
        idx0[ptag[2:1]] <= IW'(fi);
        fr0[ptag[2:1]] <= gsh[31:16];
        ok0[ptag[2:1]] <= okr;
        nidx[ptag[2:1]] <= IW'(fn);
        nok[ptag[2:1]] <= okn;
      end
    end
  end

  // ---------------- corner issue and accumulation ----------------
  always_comb begin
    q = cnt[4:3];
    k = cnt[2:0];
    iv = (state == ST_LOOK) && !cnt[5];
    cx = ((q == 2'd1) ? idx1[0] : idx0[0]) + IW'(k[0]);
    cy = ((q == 2'd2) ? idx1[1] : idx0[1]) + IW'(k[1]);
    cz = ((q == 2'd3) ? idx1[2] : idx0[2]) + IW'(k[2]);
    wx = wsel((q == 2'd1) ? fr1[0] : fr0[0], k[0]);
    wy = wsel((q == 2'd2) ? fr1[1] : fr0[1], k[1]);
    wz = wsel((q == 2'd3) ? fr1[2] : fr0[2], k[2]);
    corner_addr = addr_of(AW'(cx), AW'(cy), AW'(cz));
    near_addr = addr_of(AW'(nidx[0]), AW'(nidx[1]), AW'(nidx[2]));
    wr_addr = addr_of(AW'(q_entry.item.cell_ix), AW'(q_entry.item.cell_iy),
                      AW'(q_entry.item.cell_iz));
    wprod = wxy * 51'(wz1);
    tprod = 66'(gval) * $signed({33'b0, wt});
    sum = acc + t;
    gprod = 64'(cfg.energy_gain) * 64'(vq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      acc <= '0;
    end else begin
      v1 <= iv;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3 && l3;
      if (v3) begin
        acc <= l3 ? 64'd0 : sum;
      end
    end
    wxy <= 34'(wx) * 34'(wy);
    wz1 <= wz;
    q1 <= q;
    l1 <= (k == 3'd7);
    wt <= wprod[48:16];
    gval <= ram_rdata;
    q2 <= q1;
    l2 <= l1;
    t <= tprod[63:0];
    q3 <= q2;
    l3 <= l2;
    vq <= sum[63:32];
    q4 <= q3;
    if (v4) begin
      e[q4] <= gprod[63:16];
    end
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt <= '0;
      clr <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      clr <= clr_next;
      done <= done_next;
    end
    result <= result_next;
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    clr_next = clr;
    q_pop = 1'b0;
    ram_we = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = q_entry.item.cell_value;
    ram_raddr = (state == ST_CHECK) ? near_addr : corner_addr;
    done_next = 1'b0;
    result_next = result;
    clearing = (state == ST_CLEAR);
    fault = ~&nok | ~&ok0 | ~&ok1;
    dx = 49'(e[0]) - 49'(e[1]);
    dy = 49'(e[0]) - 49'(e[2]);
    dz = 49'(e[0]) - 49'(e[3]);
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = clr;
        ram_wdata = '0;
        clr_next = clr + AW'(1);
        if (clr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (!q_entry.item.cmd) begin
            ram_we = q_entry.wr_ok;
            done_next = 1'b1;
            result_next = '0;
            result_next.status = q_entry.wr_ok ? STAT_OK : STAT_RANGE;
          end else begin
            state_next = ST_COORD;
            cnt_next = '0;
          end
        end
      end
      ST_COORD: begin
        if (cnt == 6'd6) begin
          state_next = ST_CHECK;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_CHECK: begin
        if (fault) begin
          done_next = 1'b1;
          result_next = '0;
          result_next.status = STAT_RANGE;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_NEAR;
        end
      end
      ST_NEAR: begin
        if (ram_rdata[31]) begin
          done_next = 1'b1;
          result_next = '0;
          result_next.status = STAT_NEG;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_LOOK;
          cnt_next = '0;
        end
      end
      ST_LOOK: begin
        if (!cnt[5]) begin
          cnt_next = cnt + 6'd1;
        end
        if (v4 && q4 == 2'd3) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        done_next = 1'b1;
        result_next.status = STAT_OK;
        result_next.energy = sat32(56'(e[0]));
        result_next.force_x = sat32(56'(dx) * FORCE_SCALE);
        result_next.force_y = sat32(56'(dy) * FORCE_SCALE);
        result_next.force_z = sat32(56'(dz) * FORCE_SCALE);
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/gtf_checker.sv
// ----------------------------------------------------------------------------
// gtf_port_checks
// Port-level checks of the trilinear grid force block, bound to the top level.
// ----------------------------------------------------------------------------
module gtf_port_checks (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input gtf_pkg::gtf_out_t result
);
  import gtf_pkg::*;

  // The grid clearing pass holds off commands right after reset.
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_no_done_after_rst: assert property (@(posedge clk) rst |=> !done)
    else $error("result beat right after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == STAT_OK || result.status == STAT_RANGE ||
              result.status == STAT_NEG))
    else $error("undefined status code");

  // A faulted beat carries zero energy and forces.
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STAT_OK) |->
      (result.energy == 32'sd0 && result.force_x == 32'sd0 &&
       result.force_y == 32'sd0 && result.force_z == 32'sd0))
    else $error("nonzero payload on faulted beat");

endmodule

bind grid_trilinear_force gtf_port_checks u_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .result(result)
);
